// ----- rtl/mwfs_pkg.sv -----
// Shared types, constants and tables for the multipole wire field block.
// Used by mwfs_alu, mwfs_mul and multipole_wire_field_sum. No dependencies.
package mwfs_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int MAX_ORDER    = 6;
	localparam int TABLE_ORDERS = 6;
	localparam int LIM_ORDER    = (MAX_ORDER < TABLE_ORDERS) ? MAX_ORDER : TABLE_ORDERS;

	localparam int POS_W  = 40;  // position, offset and sum width
	localparam int LEN_W  = 41;  // vector length width
	localparam int NUM_W  = 56;  // divider numerator / quotient width
	localparam int UNIT_W = 18;  // unit vector component width
	localparam int RCP_W  = 31;  // reciprocal width

	localparam logic [LEN_W-1:0] LIMIT_Q = LEN_W'(6 * (1 << FRAC_BITS));
	localparam logic [31:0]      TENTH_Q = 32'(((1 << FRAC_BITS) + 5) / 10);
	localparam logic [RCP_W-1:0] RCP_ONE = RCP_W'(1 << FRAC_BITS);
	localparam logic [RCP_W-1:0] RCP_MAX = {RCP_W{1'b1}};

	typedef enum logic [1:0] {
		CFG_POLE_PAIRS = 2'd0,
		CFG_TIP_RADIUS = 2'd1,
		CFG_NORMALISE  = 2'd2,
		CFG_INVERT     = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ALU_DIV  = 1'b0,
		ALU_SQRT = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic             start;
		alu_op_t          op;
		logic [63:0]      num;
		logic [LEN_W-1:0] den;
	} alu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_W_X, ST_W_Y, ST_W_D, ST_W_CHK, ST_W_PUSH, ST_W_D2, ST_W_RCP,
		ST_W_RCPW, ST_W_UNIT, ST_W_VX, ST_W_VY, ST_W_ACC,
		ST_F_CHK, ST_F_UNIT, ST_F_TX, ST_F_TY, ST_F_TW, ST_F_SAT, ST_F_NX, ST_F_NY,
		ST_F_NW, ST_F_OUT,
		ST_L_ABS, ST_L_NORM, ST_L_SQB, ST_L_SUM, ST_L_ROOT,
		ST_U_X, ST_U_XW, ST_U_YW
	} state_t;

	// cos(3k deg) in Q16, k = 0..30
	localparam logic [16:0] COS_TAB [0:30] = '{
		17'd65536, 17'd65446, 17'd65177, 17'd64729, 17'd64104, 17'd63303,
		17'd62328, 17'd61183, 17'd59870, 17'd58393, 17'd56756, 17'd54963,
		17'd53020, 17'd50931, 17'd48703, 17'd46341, 17'd43852, 17'd41243,
		17'd38521, 17'd35693, 17'd32768, 17'd29753, 17'd26656, 17'd23486,
		17'd20252, 17'd16962, 17'd13626, 17'd10252, 17'd6850,  17'd3430,
		17'd0
	};

	// cosine of 3k degrees, k in 0..119
	function automatic logic signed [17:0] cos_step(input logic [6:0] k);
		logic [1:0]  q;
		logic [6:0]  r;
		logic [16:0] v;
		if (k < 7'd30) q = 2'd0;
		else if (k < 7'd60) q = 2'd1;
		else if (k < 7'd90) q = 2'd2;
		else q = 2'd3;
		r = k - 7'(q) * 7'd30;
		if (q == 2'd0 || q == 2'd2) v = COS_TAB[r[4:0]];
		else v = COS_TAB[5'(7'd30 - r)];
		if (q == 2'd1 || q == 2'd2) return -$signed({1'b0, v});
		return $signed({1'b0, v});
	endfunction

	// angular step in 3 degree units for the clamped order
	function automatic logic [6:0] step_of(input logic [2:0] n);
		logic [2:0] ne;
		ne = (n == 3'd0) ? 3'd1 : ((n > 3'(LIM_ORDER)) ? 3'(LIM_ORDER) : n);
		unique case (ne)
			3'd1:    return 7'd60;
			3'd2:    return 7'd30;
			3'd3:    return 7'd20;
			3'd4:    return 7'd15;
			3'd5:    return 7'd12;
			default: return 7'd10;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [POS_W-1:0] mag40(input logic signed [POS_W-1:0] v);
		return v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
	endfunction

endpackage

// ----- rtl/mwfs_alu.sv -----
// Iterative divide / square root unit, one bit per cycle.
// Depends on mwfs_pkg (alu_req_t, alu_rsp_t, widths).
module mwfs_alu import mwfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             busy_q, done_q;
	alu_op_t          op_q;
	logic [5:0]       cnt_q;
	logic [63:0]      acc_q, res_q, bit_q;
	logic [LEN_W:0]   rem_q;
	logic [LEN_W-1:0] den_q;

	logic [LEN_W:0] rem_sh;
	logic           div_ge, sq_ge;
	logic [63:0]    trial;

	assign rem_sh = {rem_q[LEN_W-1:0], acc_q[NUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign trial  = res_q + bit_q;
	assign sq_ge  = acc_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_DIV;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					op_q   <= req.op;
					cnt_q  <= (req.op == ALU_DIV) ? 6'(NUM_W - 1) : 6'd31;
				end
			end else begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				acc_q <= req.num;
				rem_q <= '0;
				den_q <= req.den;
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
		end else begin
			unique case (op_q)
				ALU_DIV: begin
					rem_q <= div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
					acc_q <= {acc_q[62:0], div_ge};
				end
				ALU_SQRT: begin
					if (sq_ge) begin
						acc_q <= acc_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = (op_q == ALU_DIV) ? 64'(acc_q[NUM_W-1:0]) : res_q;

endmodule

// ----- rtl/mwfs_mul.sv -----
// Registered 32x32 unsigned multiplier.
// Depends on mwfs_pkg only for the import convention.
module mwfs_mul import mwfs_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

// ----- rtl/multipole_wire_field_sum.sv -----
// Top level: multipole outer field from alternating wire sources.
// Depends on mwfs_pkg, mwfs_alu (div/sqrt) and mwfs_mul (multiplier).
//
// channel | direction | handshake           | payload
// cfg     | in        | cfg_we              | cfg_index, cfg_wdata
// in      | in        | in_valid / in_ready | pos_x, pos_y
// out     | out       | out_valid/out_ready | field_x, field_y, near_pole
//
// Run time grows with the 2*order wires, a close wire costing more than a far
// one, plus the finish (longer after a close wire) and each prescale shift of a
// length. The 56-step divider (two per unit vector, one per reciprocal) and the
// 32-step root set it. in_ready is high only while idle.
// A result waits in the output register while the next beat runs; the
// sequencer stalls in its last state only if the first has not left. Reset
// restores config and control registers only; no memory to clear.
module multipole_wire_field_sum import mwfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] field_x,
	output logic signed [31:0] field_y,
	output logic               near_pole
);

	// configuration
	logic [2:0]         pole_pairs_q;
	logic [30:0]        radius_q;
	logic signed [31:0] norm_q;
	logic               invert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_pairs_q <= 3'd2;
			radius_q     <= '0;
			norm_q       <= 32'sd65536;
			invert_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POLE_PAIRS: pole_pairs_q <= cfg_wdata[2:0];
				CFG_TIP_RADIUS: radius_q     <= cfg_wdata[30:0];
				CFG_NORMALISE:  norm_q       <= cfg_wdata;
				CFG_INVERT:     invert_q     <= cfg_wdata[0];
			endcase
		end
	end

	// sequencer and datapath registers
	state_t state_q, state_n, ret_q;

	logic signed [POS_W-1:0]  px_q, py_q, wx_q, wy_q, opx_q, opy_q, sx_q, sy_q;
	logic [POS_W-1:0]         ma_q, mb_q;
	logic [3:0]               sh_q;
	logic [63:0]              acc_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [UNIT_W-1:0] ux_q, uy_q;
	logic [RCP_W-1:0]         rcp_q;
	logic signed [32:0]       tx_q, ty_q;
	logic [3:0]               i_q;
	logic [6:0]               k_q;
	logic                     close_q;
	logic                     out_valid_q, near_q;
	logic signed [31:0]       fx_q, fy_q;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	mwfs_alu u_alu (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(alu_rsp));
	mwfs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	// helpers
	logic [3:0]               nwire;
	logic [2:0]               n_eff;
	logic [6:0]               step;
	logic [7:0]               k90_sum, kn_sum;
	logic [6:0]               k90, k_n;
	logic signed [17:0]       cos_k, sin_k;
	logic [16:0]              cos_mag, sin_mag;
	logic signed [48:0]       pq;
	logic [31:0]              uxm, uym, txm, tym, normm;
	logic                     big;
	logic signed [POS_W-1:0]  wy_new;
	logic signed [UNIT_W-1:0] qu;
	logic signed [31:0]       sat_x, sat_y;
	logic signed [POS_W-1:0]  ux6, uy6;
	logic [NUM_W-1:0]         numx, numy;

	assign n_eff   = (pole_pairs_q == 3'd0) ? 3'd1 :
		((pole_pairs_q > 3'(LIM_ORDER)) ? 3'(LIM_ORDER) : pole_pairs_q);
	assign nwire   = {n_eff, 1'b0};
	assign step    = step_of(pole_pairs_q);
	assign k90_sum = {1'b0, k_q} + 8'd90;
	assign k90     = (k90_sum >= 8'd120) ? 7'(k90_sum - 8'd120) : k90_sum[6:0];
	assign kn_sum  = {1'b0, k_q} + {1'b0, step};
	assign k_n     = (kn_sum >= 8'd120) ? 7'(kn_sum - 8'd120) : kn_sum[6:0];
	assign cos_k   = cos_step(k_q);
	assign sin_k   = cos_step(k90);
	assign cos_mag = cos_k[17] ? 17'(-cos_k) : cos_k[16:0];
	assign sin_mag = sin_k[17] ? 17'(-sin_k) : sin_k[16:0];

	// product magnitude after the Q16 shift
	assign pq     = $signed({1'b0, mul_p[63:16]});
	assign uxm    = ux_q[UNIT_W-1] ? 32'(-ux_q) : 32'(ux_q);
	assign uym    = uy_q[UNIT_W-1] ? 32'(-uy_q) : 32'(uy_q);
	assign txm    = tx_q[32] ? 32'(-tx_q) : tx_q[31:0];
	assign tym    = ty_q[32] ? 32'(-ty_q) : ty_q[31:0];
	assign normm  = norm_q[31] ? 32'(-33'(norm_q)) : norm_q;
	assign big    = (ma_q[POS_W-1:31] != '0) || (mb_q[POS_W-1:31] != '0);
	assign wy_new = sin_k[17] ? POS_W'(-pq) : POS_W'(pq);
	assign qu     = $signed({1'b0, alu_rsp.res[UNIT_W-2:0]});
	assign sat_x  = sat32(64'(sx_q));
	assign sat_y  = sat32(64'(sy_q));
	assign ux6    = (POS_W'(ux_q) <<< 2) + (POS_W'(ux_q) <<< 1);
	assign uy6    = (POS_W'(uy_q) <<< 2) + (POS_W'(uy_q) <<< 1);
	assign numx   = {mag40(opx_q), 16'd0};
	assign numy   = {mag40(opy_q), 16'd0};

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_n = ST_W_X;
			ST_W_X:    state_n = ST_W_Y;
			ST_W_Y:    state_n = ST_W_D;
			ST_W_D:    state_n = ST_L_ABS;
			ST_W_CHK:  state_n = (len_q < LIMIT_Q) ? ST_U_X : ST_W_RCP;
			ST_W_PUSH: state_n = ST_W_D2;
			ST_W_D2:   state_n = ST_L_ABS;
			ST_W_RCP:  state_n = (len_q == '0) ? ST_W_UNIT : ST_W_RCPW;
			ST_W_RCPW: if (alu_rsp.done) state_n = ST_W_UNIT;
			ST_W_UNIT: state_n = ST_U_X;
			ST_W_VX:   state_n = ST_W_VY;
			ST_W_VY:   state_n = ST_W_ACC;
			ST_W_ACC:  state_n = (i_q == nwire - 4'd1) ? ST_F_CHK : ST_W_X;
			ST_F_CHK:  state_n = close_q ? ST_L_ABS : ST_F_SAT;
			ST_F_UNIT: state_n = ST_U_X;
			ST_F_TX:   state_n = ST_F_TY;
			ST_F_TY:   state_n = ST_F_TW;
			ST_F_TW:   state_n = ST_F_SAT;
			ST_F_SAT:  state_n = ST_F_NX;
			ST_F_NX:   state_n = ST_F_NY;
			ST_F_NY:   state_n = ST_F_NW;
			ST_F_NW:   state_n = ST_F_OUT;
			ST_F_OUT:  if (!out_valid_q || out_ready) state_n = ST_IDLE;
			ST_L_ABS:  state_n = ST_L_NORM;
			ST_L_NORM: if (!big) state_n = ST_L_SQB;
			ST_L_SQB:  state_n = ST_L_SUM;
			ST_L_SUM:  state_n = ST_L_ROOT;
			ST_L_ROOT: if (alu_rsp.done) state_n = ret_q;
			ST_U_X:    state_n = (len_q == '0) ? ret_q : ST_U_XW;
			ST_U_XW:   if (alu_rsp.done) state_n = ST_U_YW;
			ST_U_YW:   if (alu_rsp.done) state_n = ret_q;
			default:   state_n = ST_IDLE;
		endcase
	end

	// unit operands and starts
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		alu_req.start = 1'b0;
		alu_req.op    = ALU_DIV;
		alu_req.num   = '0;
		alu_req.den   = len_q;
		unique case (state_q)
			ST_W_X: begin
				mul_a = 32'(radius_q);
				mul_b = 32'(cos_mag);
			end
			ST_W_Y: begin
				mul_a = 32'(radius_q);
				mul_b = 32'(sin_mag);
			end
			ST_L_NORM: begin
				mul_a = ma_q[31:0];
				mul_b = ma_q[31:0];
			end
			ST_L_SQB: begin
				mul_a = mb_q[31:0];
				mul_b = mb_q[31:0];
			end
			ST_L_SUM: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_SQRT;
				alu_req.num   = acc_q + mul_p;
			end
			ST_U_X: begin
				alu_req.start = (len_q != '0);
				alu_req.num   = 64'(numx);
			end
			ST_U_XW: begin
				alu_req.start = alu_rsp.done;
				alu_req.num   = 64'(numy);
			end
			ST_W_RCP: begin
				alu_req.start = (len_q != '0);
				alu_req.num   = 64'd1 << (2 * FRAC_BITS);
			end
			ST_W_VX: begin
				mul_a = uym;
				mul_b = 32'(rcp_q);
			end
			ST_W_VY: begin
				mul_a = uxm;
				mul_b = 32'(rcp_q);
			end
			ST_F_TX: begin
				mul_a = uxm;
				mul_b = TENTH_Q;
			end
			ST_F_TY: begin
				mul_a = uym;
				mul_b = TENTH_Q;
			end
			ST_F_NX: begin
				mul_a = txm;
				mul_b = normm;
			end
			ST_F_NY: begin
				mul_a = tym;
				mul_b = normm;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_n;
			// a new result replaces the one leaving in the same cycle
			if (state_q == ST_F_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					close_q <= 1'b0;
					i_q     <= '0;
					k_q     <= '0;
				end
				ST_W_D:    ret_q <= ST_W_CHK;
				ST_W_CHK:  if (len_q < LIMIT_Q) ret_q <= ST_W_PUSH;
				ST_W_PUSH: close_q <= 1'b1;
				ST_W_D2:   ret_q <= ST_W_RCP;
				ST_W_UNIT: ret_q <= ST_W_VX;
				ST_W_ACC: begin
					i_q <= i_q + 4'd1;
					k_q <= k_n;
				end
				ST_F_CHK:  ret_q <= ST_F_UNIT;
				ST_F_UNIT: ret_q <= ST_F_TX;
				default:   ret_q <= ret_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				px_q <= POS_W'(pos_x);
				py_q <= POS_W'(pos_y);
				sx_q <= '0;
				sy_q <= '0;
			end
			ST_W_Y: wx_q <= cos_k[17] ? POS_W'(-pq) : POS_W'(pq);
			ST_W_D: begin
				wy_q  <= wy_new;
				opx_q <= px_q - wx_q;
				opy_q <= py_q - wy_new;
			end
			ST_W_PUSH: begin
				px_q <= px_q + ux6;
				py_q <= py_q + uy6;
			end
			ST_W_D2: begin
				opx_q <= px_q - wx_q;
				opy_q <= py_q - wy_q;
			end
			ST_W_RCP: if (len_q == '0) rcp_q <= RCP_ONE;
			ST_W_RCPW: if (alu_rsp.done) begin
				rcp_q <= (alu_rsp.res > 64'(RCP_MAX)) ? RCP_MAX : alu_rsp.res[RCP_W-1:0];
			end
			// -uy * recip: negative when uy is positive
			ST_W_VY: begin
				if (i_q[0]) sx_q <= sx_q - ((uy_q > 0) ? POS_W'(-pq) : POS_W'(pq));
				else sx_q <= sx_q + ((uy_q > 0) ? POS_W'(-pq) : POS_W'(pq));
			end
			ST_W_ACC: begin
				if (i_q[0]) sy_q <= sy_q - (ux_q[UNIT_W-1] ? POS_W'(-pq) : POS_W'(pq));
				else sy_q <= sy_q + (ux_q[UNIT_W-1] ? POS_W'(-pq) : POS_W'(pq));
			end
			ST_F_CHK: begin
				opx_q <= sx_q;
				opy_q <= sy_q;
			end
			ST_F_TY: sx_q <= ux_q[UNIT_W-1] ? POS_W'(-pq) : POS_W'(pq);
			ST_F_TW: sy_q <= uy_q[UNIT_W-1] ? POS_W'(-pq) : POS_W'(pq);
			ST_F_SAT: begin
				tx_q <= invert_q ? -33'(sat_x) : 33'(sat_x);
				ty_q <= invert_q ? -33'(sat_y) : 33'(sat_y);
			end
			ST_F_NY: sx_q <= POS_W'(sat32(64'((tx_q[32] ^ norm_q[31]) ? -pq : pq)));
			ST_F_NW: sy_q <= POS_W'(sat32(64'((ty_q[32] ^ norm_q[31]) ? -pq : pq)));
			ST_F_OUT: if (!out_valid_q || out_ready) begin
				fx_q   <= sx_q[31:0];
				fy_q   <= sy_q[31:0];
				near_q <= close_q;
			end
			ST_L_ABS: begin
				ma_q <= mag40(opx_q);
				mb_q <= mag40(opy_q);
				sh_q <= '0;
			end
			// bring both magnitudes below 2^31, one bit a cycle
			ST_L_NORM: if (big) begin
				ma_q <= ma_q >> 1;
				mb_q <= mb_q >> 1;
				sh_q <= sh_q + 4'd1;
			end
			ST_L_SQB: acc_q <= mul_p;
			ST_L_ROOT: if (alu_rsp.done) len_q <= LEN_W'(alu_rsp.res[31:0]) << sh_q;
			ST_U_X: if (len_q == '0) begin
				ux_q <= '0;
				uy_q <= '0;
			end
			ST_U_XW: if (alu_rsp.done) ux_q <= opx_q[POS_W-1] ? -qu : qu;
			ST_U_YW: if (alu_rsp.done) uy_q <= opy_q[POS_W-1] ? -qu : qu;
			default: acc_q <= acc_q;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign field_x   = fx_q;
	assign field_y   = fy_q;
	assign near_pole = near_q;

	// divider/root completion only lands where the sequencer waits for it
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == ST_L_ROOT || state_q == ST_U_XW ||
			state_q == ST_U_YW || state_q == ST_W_RCPW))
		else $error("divider result with no waiting state");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_W_X))
		else $error("accepted beat did not start the wire loop");

	a_wire_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_ACC) |-> (i_q < nwire))
		else $error("wire index past the source count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_OUT && out_valid && !out_ready) |=> (state_q == ST_F_OUT))
		else $error("result overwrote a pending output beat");

endmodule

// ----- verif/tb_multipole_wire_field_sum.sv -----
`timescale 1ns / 1ps
// Testbench for multipole_wire_field_sum: directed and random positions under
// several register settings, checked beat by beat against an in-bench model.
// Depends on mwfs_pkg and the RTL of multipole_wire_field_sum only.
module tb_multipole_wire_field_sum;
	import mwfs_pkg::*;

	localparam longint Q1        = 64'sd65536;
	localparam longint NEAR_Q    = 6 * Q1;       // 6 mm keep-out radius
	localparam longint TENTH     = 6554;         // 0.1 in Q16, rounded
	localparam longint NANO      = 1000000000;
	localparam longint CYCLE_CAP = 40000000;     // watchdog on the run's cycle count
	localparam int     HOLD_LEN  = 9000;         // long output back-pressure

	// cos(3k deg) * 1e9, k = 0..30
	localparam longint COS_NANO [0:30] = '{
		1000000000, 998629535, 994521895, 987688341, 978147601, 965925826,
		951056516, 933580426, 913545458, 891006524, 866025404, 838670568,
		809016994, 777145961, 743144825, 707106781, 669130606, 629320391,
		587785252, 544639035, 500000000, 453990500, 406736643, 358367950,
		309016994, 258819045, 207911691, 156434465, 104528463, 52335956, 0
	};

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pos_beat_t;

	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               near;
	} field_beat_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic               near_pole;

	multipole_wire_field_sum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.field_x   (field_x),
		.field_y   (field_y),
		.near_pole (near_pole)
	);

	// shadow copy of the block's registers, reset values
	logic [2:0]  m_pairs  = 3'd2;
	logic [30:0] m_radius = '0;
	longint      m_norm   = 65536;
	logic        m_invert = 1'b0;

	pos_beat_t   pending_pos[$];
	field_beat_t field_due[$];

	int     errors     = 0;
	int     beats_sent = 0;   // beats raised by the driver
	int     beats_in   = 0;   // beats taken by the block
	int     beats_out  = 0;
	longint cycles     = 0;
	int     send_idle  = 0;   // percent of cycles the sender sits out
	int     recv_idle  = 0;   // percent of cycles the receiver stalls
	int     hold_left  = 0;
	bit     hold_done  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- field model ----------------

	function automatic longint q_mul(longint a, longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p  = (ma * mb) >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// cos(3k deg) in Q16 for k in 0..119, rounded from the nano table
	function automatic longint wire_cos(int k);
		int     quad, rem;
		longint v, qv;
		quad = (k / 30) & 3;
		rem  = k % 30;
		v  = (quad == 0 || quad == 2) ? COS_NANO[rem] : COS_NANO[30 - rem];
		qv = (v * Q1 + NANO / 2) / NANO;
		return (quad == 1 || quad == 2) ? -qv : qv;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// |(x,y)|, prescaled so each magnitude fits below 2^31
	function automatic longint vec_len(longint x, longint y);
		longint unsigned a, b;
		int sh;
		a  = (x < 0) ? -x : x;
		b  = (y < 0) ? -y : y;
		sh = 0;
		while ((a >> sh) >= 64'h8000_0000 || (b >> sh) >= 64'h8000_0000) sh++;
		a = a >> sh;
		b = b >> sh;
		return longint'(floor_root(a * a + b * b) << sh);
	endfunction

	function automatic void unit_vec(input longint x, y, len, output longint ux, uy);
		if (len == 0) begin
			ux = 0;
			uy = 0;
		end else begin
			ux = (x * Q1) / len;
			uy = (y * Q1) / len;
		end
	endfunction

	function automatic int eff_pairs(logic [2:0] n);
		if (n == 0) return 1;
		if (n > LIM_ORDER) return LIM_ORDER;
		return n;
	endfunction

	function automatic field_beat_t wire_field(pos_beat_t p);
		field_beat_t r;
		longint px, py, sx, sy, wx, wy, dx, dy, len, ux, uy, rcp, vx, vy;
		int     n, k;
		bit     near;
		px   = p.x;
		py   = p.y;
		sx   = 0;
		sy   = 0;
		near = 0;
		n    = eff_pairs(m_pairs);
		for (int i = 0; i < 2 * n; i++) begin
			k   = (i * (60 / n)) % 120;
			wx  = q_mul(longint'(m_radius), wire_cos(k));
			wy  = q_mul(longint'(m_radius), wire_cos((k + 90) % 120));
			dx  = px - wx;
			dy  = py - wy;
			len = vec_len(dx, dy);
			if (len < NEAR_Q) begin
				// push out along the same direction; the moved point sticks
				unit_vec(dx, dy, len, ux, uy);
				px   = px + ux * 6;
				py   = py + uy * 6;
				dx   = px - wx;
				dy   = py - wy;
				len  = vec_len(dx, dy);
				near = 1;
			end
			if (len == 0) rcp = Q1;
			else begin
				rcp = longint'((64'd1 << 32) / longint'(len));
				if (rcp > 64'sd2147483647) rcp = 64'sd2147483647;
			end
			unit_vec(dx, dy, len, ux, uy);
			vx = q_mul(-uy, rcp);
			vy = q_mul(ux, rcp);
			if (i % 2) begin
				sx = sx - vx;
				sy = sy - vy;
			end else begin
				sx = sx + vx;
				sy = sy + vy;
			end
		end
		if (near) begin
			unit_vec(sx, sy, vec_len(sx, sy), ux, uy);
			sx = q_mul(ux, TENTH);
			sy = q_mul(uy, TENTH);
		end
		sx = sat_s32(sx);
		sy = sat_s32(sy);
		if (m_invert) begin
			sx = -sx;
			sy = -sy;
		end
		r.fx   = 32'(sat_s32(q_mul(sx, m_norm)));
		r.fy   = 32'(sat_s32(q_mul(sy, m_norm)));
		r.near = near;
		return r;
	endfunction

	// ---------------- driver, receiver, monitor ----------------

	// beat is still pending while beats_in lags beats_sent
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beats_in == beats_sent)) begin
			if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle) begin
				pos_x      <= pending_pos[0].x;
				pos_y      <= pending_pos[0].y;
				in_valid   <= 1'b1;
				beats_sent <= beats_sent + 1;
				void'(pending_pos.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver; one long hold once enough beats went through, so the block
	// fills its output register and drops in_ready while beats are offered
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && beats_out >= 60) begin
			hold_done <= 1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		field_beat_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (in_valid && in_ready) begin
			field_due = {field_due, wire_field('{x: pos_x, y: pos_y})};
			beats_in <= beats_in + 1;
		end
		if (out_valid && out_ready) begin
			beats_out <= beats_out + 1;
			if (field_due.size() == 0) begin
				$error("unexpected beat: field_x %0d field_y %0d", field_x, field_y);
				errors++;
			end else begin
				want = field_due.pop_front();
				if (field_x !== want.fx) begin
					$error("field_x: expected %0d, got %0d", want.fx, field_x);
					errors++;
				end
				if (field_y !== want.fy) begin
					$error("field_y: expected %0d, got %0d", want.fy, field_y);
					errors++;
				end
				if (near_pole !== want.near) begin
					$error("near_pole: expected %0d, got %0d", want.near, near_pole);
					errors++;
				end
			end
		end
	end

	// ---------------- stimulus ----------------

	task automatic queue_pos(pos_beat_t p);
		pending_pos = {pending_pos, p};
	endtask

	task automatic reg_write(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLE_PAIRS: m_pairs  = val[2:0];
			CFG_TIP_RADIUS: m_radius = val[30:0];
			CFG_NORMALISE:  m_norm   = longint'(signed'(val));
			CFG_INVERT:     m_invert = val[0];
		endcase
	endtask

	// block idle: nothing queued, nothing in flight, finish state drained
	task automatic drain();
		while (pending_pos.size() > 0 || in_valid || field_due.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_regs(logic [2:0] n, logic [30:0] r, logic [31:0] nm, logic inv);
		drain();
		reg_write(CFG_POLE_PAIRS, 32'(n));
		reg_write(CFG_TIP_RADIUS, 32'(r));
		reg_write(CFG_NORMALISE, nm);
		reg_write(CFG_INVERT, 32'(inv));
	endtask

	function automatic logic signed [31:0] clip32(longint v);
		return 32'(sat_s32(v));
	endfunction

	function automatic pos_beat_t at(longint x, longint y);
		return '{x: clip32(x), y: clip32(y)};
	endfunction

	// position near a wire of the current setting, offset up to spread mm
	function automatic pos_beat_t near_wire(int spread);
		int     n, k;
		longint ox, oy;
		n  = eff_pairs(m_pairs);
		k  = ($urandom_range(2 * n - 1) * (60 / n)) % 120;
		ox = longint'($urandom_range(2 * spread * 65536)) - spread * Q1;
		oy = longint'($urandom_range(2 * spread * 65536)) - spread * Q1;
		return at(q_mul(longint'(m_radius), wire_cos(k)) + ox,
			q_mul(longint'(m_radius), wire_cos((k + 90) % 120)) + oy);
	endfunction

	function automatic pos_beat_t random_pos();
		int     pick;
		longint span;
		pick = $urandom_range(9);
		span = longint'(m_radius) * 2 + 20 * Q1;
		if (pick < 4) return near_wire(10);                    // near a wire's keep-out zone
		if (pick < 8) return at(longint'($urandom_range(32'(span))) - span / 2,
			longint'($urandom_range(32'(span))) - span / 2);   // around the bore
		return '{x: $urandom, y: $urandom};                     // anywhere
	endfunction

	initial begin
		logic [30:0] rads [0:3];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_POLE_PAIRS;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		pos_x     = '0;
		pos_y     = '0;
		send_idle = 21;
		recv_idle = 76;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting, radius 0: every wire sits on the origin
		queue_pos(at(0, 0));
		queue_pos(at(3 * Q1, -2 * Q1));
		queue_pos(at(40 * Q1, 25 * Q1));

		// directed at radius 50 mm, quadrupole
		set_regs(3'd2, 31'(50 * 65536), 32'd65536, 1'b0);
		queue_pos(at(0, 0));
		queue_pos(at(50 * Q1, 0));                 // exactly on a wire
		queue_pos(at(0, 50 * Q1));
		queue_pos(at(56 * Q1, 0));                 // exactly 6 mm off
		queue_pos(at(56 * Q1 - 1, 0));             // just inside
		queue_pos('{x: 32'sh7fffffff, y: 32'sh7fffffff});
		queue_pos('{x: 32'sh80000000, y: 32'sh80000000});
		queue_pos('{x: 32'sh7fffffff, y: 32'sh80000000});
		queue_pos('{x: -1, y: 1});

		// order clamping: 0 acts as 1, 7 as the table limit
		set_regs(3'd0, 31'(30 * 65536), 32'hffff0000, 1'b1);
		queue_pos(at(10 * Q1, 5 * Q1));
		queue_pos(at(-30 * Q1, 2 * Q1));
		set_regs(3'd7, 31'(30 * 65536), 32'h7fffffff, 1'b0);
		queue_pos(at(1 * Q1, 1 * Q1));
		queue_pos(at(29 * Q1, 0));
		set_regs(3'd6, 31'h7fffffff, 32'h80000000, 1'b1);
		queue_pos(at(0, 0));
		queue_pos('{x: 32'sh7fffffff, y: 0});
		set_regs(3'd1, 31'd1, 32'd0, 1'b0);
		queue_pos(at(5 * Q1, 5 * Q1));

		// random phases: fresh setting each, small radii mostly
		rads = '{31'(20 * 65536), 31'(80 * 65536), 31'(3 * 65536), 31'h7fffffff};
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle = 76;
				recv_idle = 21;
			end else if (ph == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_regs(3'($urandom_range(7)),
				($urandom_range(3) == 0) ? 31'($urandom) : rads[$urandom_range(3)],
				($urandom_range(2) == 0) ? $urandom : 32'($urandom_range(131072)) - 32'd65536,
				1'($urandom_range(1)));
			for (int i = 0; i < 100; i++) queue_pos(random_pos());
		end

		drain();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
